// File: rtl/sjd_pkg.sv
package sjd_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    MODE_PUSH   = 3'd0,
    MODE_INSERT = 3'd1,
    MODE_AMEND  = 3'd2,
    MODE_POP    = 3'd3,
    MODE_CLEAR  = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_PUSH,
    CELL_INSERT,
    CELL_AMEND,
    CELL_POP
  } cell_op_t;

  typedef struct packed {
    logic [5:0] block;
    logic [1:0] operation;
    logic [3:0] notify;
  } entry_t;

  typedef struct packed {
    cell_op_t op;
    entry_t   job;
  } cell_cmd_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [5:0] job_block;
    logic [1:0] job_operation;
    logic [3:0] job_notify;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] head_block;
    logic [1:0] head_operation;
    logic [3:0] head_notify;
    logic       pending;
    logic [6:0] fill_count;
  } rsp_t;

endpackage

// File: rtl/sjd_cell.sv
module sjd_cell (
  input  logic              clk,
  input  sjd_pkg::cell_cmd_t cmd,
  input  logic              sel_tail,
  input  logic              sel_last,
  input  sjd_pkg::entry_t   left,
  input  sjd_pkg::entry_t   right,
  output sjd_pkg::entry_t   entry
);

  sjd_pkg::entry_t entry_next;

  always_comb begin
    entry_next = entry;
    case (cmd.op)
      sjd_pkg::CELL_PUSH:   if (sel_tail) entry_next = cmd.job;
      sjd_pkg::CELL_INSERT: entry_next = left;
      sjd_pkg::CELL_AMEND:  if (sel_last) entry_next.notify = cmd.job.notify;
      sjd_pkg::CELL_POP:    entry_next = right;
      default:              entry_next = entry;
    endcase
  end

  // payload only: no reset
  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

// File: rtl/shifting_job_deque.sv
// Channel | Valid     | Stall     | Payload       | Direction
// req     | req_valid | req_stall | req (req_t)   | command in
// rsp     | rsp_valid | rsp_stall | rsp (rsp_t)   | one result out per command
//
// One command per cycle while req_stall is low: every entry sits in its own
// cell, and all cells shift or load together in the cycle the command transfers.
// The result appears in the output register in the cycle after the transfer.
// req_stall rises only while a result waits and rsp_stall holds it.
// Synchronous reset empties the queue and the output register; cell
// contents are left as they are and never read before written.
module shifting_job_deque (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  sjd_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output sjd_pkg::rsp_t rsp
);

  localparam int D = sjd_pkg::QUEUE_DEPTH;
  localparam int W = sjd_pkg::CNT_W;

  logic [W-1:0]       count;
  logic [W-1:0]       count_next;
  logic               accept;
  logic               full;
  logic               empty;
  sjd_pkg::cell_cmd_t cmd;
  sjd_pkg::status_t   status;
  sjd_pkg::entry_t    popped;
  sjd_pkg::rsp_t      rsp_next;
  sjd_pkg::entry_t    entries [D];
  logic [D-1:0]       sel_tail;
  logic [D-1:0]       sel_last;

  // hold the command while a result still waits downstream
  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;

  assign full  = (count == W'(D));
  assign empty = (count == '0);

  // decode the command, gating shifts that full or empty forbid
  always_comb begin
    cmd.op    = sjd_pkg::CELL_HOLD;
    cmd.job   = '{block: req.job_block, operation: req.job_operation,
                  notify: req.job_notify};
    status    = sjd_pkg::ST_OK;
    popped    = '0;
    count_next = count;
    unique case (sjd_pkg::mode_t'(req.mode))
      sjd_pkg::MODE_PUSH: begin
        if (full) begin
          status = sjd_pkg::ST_FULL;
        end else begin
          cmd.op     = sjd_pkg::CELL_PUSH;
          count_next = count + W'(1);
        end
      end
      sjd_pkg::MODE_INSERT: begin
        if (full) begin
          status = sjd_pkg::ST_FULL;
        end else begin
          cmd.op     = sjd_pkg::CELL_INSERT;
          count_next = count + W'(1);
        end
      end
      sjd_pkg::MODE_AMEND: begin
        if (empty) begin
          status = sjd_pkg::ST_EMPTY;
        end else begin
          cmd.op = sjd_pkg::CELL_AMEND;
        end
      end
      sjd_pkg::MODE_POP: begin
        if (empty) begin
          status = sjd_pkg::ST_EMPTY;
        end else begin
          cmd.op     = sjd_pkg::CELL_POP;
          popped     = entries[0];
          count_next = count - W'(1);
        end
      end
      sjd_pkg::MODE_CLEAR: begin
        count_next = '0;
      end
      default: begin
        // unused modes: no operation
      end
    endcase
    // drop the whole command unless it transfers this cycle
    if (!accept) begin
      cmd.op     = sjd_pkg::CELL_HOLD;
      count_next = count;
    end
  end

  always_comb begin
    rsp_next.status         = status;
    rsp_next.head_block     = popped.block;
    rsp_next.head_operation = popped.operation;
    rsp_next.head_notify    = popped.notify;
    rsp_next.pending        = (count_next != '0);
    rsp_next.fill_count     = 7'(count_next);
  end

  // the chain: cell 0 takes the new job on a head insert, the last cell
  // pulls in a don't-care value on a pop (it lies beyond the count)
  for (genvar i = 0; i < D; i++) begin : g_cell
    assign sel_tail[i] = (count == W'(i));
    assign sel_last[i] = (count == W'(i + 1));
    if (i == 0 && D > 1) begin : g_first
      sjd_cell u_cell (
        .clk(clk), .cmd(cmd), .sel_tail(sel_tail[i]), .sel_last(sel_last[i]),
        .left(cmd.job), .right(entries[i+1]), .entry(entries[i])
      );
    end else if (i == D - 1) begin : g_end
      sjd_cell u_cell (
        .clk(clk), .cmd(cmd), .sel_tail(sel_tail[i]), .sel_last(sel_last[i]),
        .left(entries[i-1]), .right(cmd.job), .entry(entries[i])
      );
    end else begin : g_mid
      sjd_cell u_cell (
        .clk(clk), .cmd(cmd), .sel_tail(sel_tail[i]), .sel_last(sel_last[i]),
        .left(entries[i-1]), .right(entries[i+1]), .entry(entries[i])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // advance the result register on every transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

endmodule

// File: test/tb_shifting_job_deque.sv
// Scoreboard for the job deque: mirrors the queue contents and count, works
// out the result of every command that transfers, and checks results in order.
class deque_shadow;
  sjd_pkg::entry_t slots [sjd_pkg::QUEUE_DEPTH];
  int unsigned     occupancy;
  sjd_pkg::rsp_t   awaited_results [$];
  int              errors;

  function new();
    occupancy = 0;
    errors    = 0;
  endfunction

  // Apply one accepted command to the shadow queue and queue its result.
  function void note_command(sjd_pkg::req_t cmd);
    sjd_pkg::rsp_t   res;
    sjd_pkg::entry_t job;
    sjd_pkg::entry_t head;
    int unsigned     i;
    res            = '0;
    head           = '0;
    job.block      = cmd.job_block;
    job.operation  = cmd.job_operation;
    job.notify     = cmd.job_notify;
    case (cmd.mode)
      sjd_pkg::MODE_PUSH: begin
        if (occupancy >= sjd_pkg::QUEUE_DEPTH) begin
          res.status = sjd_pkg::ST_FULL;
        end else begin
          slots[occupancy] = job;
          occupancy++;
        end
      end
      sjd_pkg::MODE_INSERT: begin
        if (occupancy >= sjd_pkg::QUEUE_DEPTH) begin
          res.status = sjd_pkg::ST_FULL;
        end else begin
          for (i = occupancy; i > 0; i--) slots[i] = slots[i-1];
          slots[0] = job;
          occupancy++;
        end
      end
      sjd_pkg::MODE_AMEND: begin
        if (occupancy == 0) res.status = sjd_pkg::ST_EMPTY;
        else slots[occupancy-1].notify = cmd.job_notify;
      end
      sjd_pkg::MODE_POP: begin
        if (occupancy == 0) begin
          res.status = sjd_pkg::ST_EMPTY;
        end else begin
          head = slots[0];
          for (i = 1; i < occupancy; i++) slots[i-1] = slots[i];
          occupancy--;
        end
      end
      sjd_pkg::MODE_CLEAR: occupancy = 0;
      default: ;
    endcase
    res.head_block     = head.block;
    res.head_operation = head.operation;
    res.head_notify    = head.notify;
    res.pending        = (occupancy != 0);
    res.fill_count     = occupancy[6:0];
    awaited_results.push_back(res);
  endfunction

  function void compare_field(string label, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
    end
  endfunction

  function void check_result(sjd_pkg::rsp_t got);
    sjd_pkg::rsp_t want;
    if (awaited_results.size() == 0) begin
      errors++;
      $display("%0t: result with nothing expected, expected none, actual %p", $time, got);
      return;
    end
    want = awaited_results.pop_front();
    compare_field("status", want.status, got.status);
    compare_field("head_block", want.head_block, got.head_block);
    compare_field("head_operation", want.head_operation, got.head_operation);
    compare_field("head_notify", want.head_notify, got.head_notify);
    compare_field("pending", want.pending, got.pending);
    compare_field("fill_count", want.fill_count, got.fill_count);
  endfunction
endclass

module tb_shifting_job_deque;

  localparam int CYCLE_LIMIT = 100000;
  localparam int FILL_PHASE  = 0;
  localparam int DRAIN_PHASE = 1;
  localparam int MIX_PHASE   = 2;
  // Mode codes the block treats as no-ops.
  localparam logic [2:0] FIRST_UNUSED_MODE = 3'd5;
  localparam logic [2:0] LAST_UNUSED_MODE  = 3'd7;

  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          req_valid = 1'b0;
  logic          req_stall;
  sjd_pkg::req_t req       = '0;
  logic          rsp_valid;
  logic          rsp_stall = 1'b0;
  sjd_pkg::rsp_t rsp;

  // Set while both sides must run without gaps.
  logic no_gaps   = 1'b0;
  int   cycles    = 0;

  deque_shadow shadow;

  shifting_job_deque u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case the handshake hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_shifting_job_deque: FAIL");
      $finish;
    end
  end

  // Receiver: stall at random, except during the gap-free stretch.
  always @(negedge clk) begin
    rsp_stall <= !no_gaps && ($urandom_range(99) < 15);
  end

  // Check every result that transfers.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) shadow.check_result(rsp);
  end

  function automatic sjd_pkg::req_t make_cmd(logic [2:0] mode, logic [5:0] blk,
                                             logic [1:0] op, logic [3:0] ntf);
    sjd_pkg::req_t cmd;
    cmd.mode          = mode;
    cmd.job_block     = blk;
    cmd.job_operation = op;
    cmd.job_notify    = ntf;
    return cmd;
  endfunction

  // Bias the command mix per phase: fill to the top, drain to the bottom, or mix.
  function automatic logic [2:0] pick_mode(int phase);
    int roll;
    roll = $urandom_range(99);
    case (phase)
      FILL_PHASE: begin
        if (roll < 48)      return sjd_pkg::MODE_PUSH;
        else if (roll < 95) return sjd_pkg::MODE_INSERT;
        else if (roll < 98) return sjd_pkg::MODE_AMEND;
        else                return sjd_pkg::MODE_POP;
      end
      DRAIN_PHASE: begin
        if (roll < 88)      return sjd_pkg::MODE_POP;
        else if (roll < 93) return sjd_pkg::MODE_AMEND;
        else if (roll < 97) return sjd_pkg::MODE_PUSH;
        else                return sjd_pkg::MODE_INSERT;
      end
      default: begin
        if (roll < 22)      return sjd_pkg::MODE_PUSH;
        else if (roll < 44) return sjd_pkg::MODE_INSERT;
        else if (roll < 62) return sjd_pkg::MODE_AMEND;
        else if (roll < 84) return sjd_pkg::MODE_POP;
        else if (roll < 88) return sjd_pkg::MODE_CLEAR;
        else                return 3'($urandom_range(LAST_UNUSED_MODE, FIRST_UNUSED_MODE));
      end
    endcase
  endfunction

  // Present one command at the falling edge and hold it until it transfers.
  // Enter and leave on a falling edge.
  task automatic send_command(sjd_pkg::req_t cmd);
    req       <= cmd;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    shadow.note_command(cmd);
    @(negedge clk);
    if (!no_gaps && $urandom_range(99) < 15) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
  endtask

  task automatic run_phase(int phase, int count);
    int n;
    for (n = 0; n < count; n++) begin
      send_command(make_cmd(pick_mode(phase), 6'($urandom_range(63)),
                            2'($urandom_range(3)), 4'($urandom_range(15))));
    end
  endtask

  initial begin
    int round;
    shadow = new();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty-queue cases, field extremes, ordering, no-op modes.
    send_command(make_cmd(sjd_pkg::MODE_POP, 6'd0, 2'd0, 4'd0));
    send_command(make_cmd(sjd_pkg::MODE_AMEND, 6'd63, 2'd3, 4'd15));
    send_command(make_cmd(sjd_pkg::MODE_CLEAR, 6'd0, 2'd0, 4'd0));
    send_command(make_cmd(sjd_pkg::MODE_PUSH, 6'd63, 2'd3, 4'd15));
    send_command(make_cmd(sjd_pkg::MODE_PUSH, 6'd0, 2'd0, 4'd0));
    send_command(make_cmd(sjd_pkg::MODE_INSERT, 6'd42, 2'd2, 4'd9));
    send_command(make_cmd(sjd_pkg::MODE_AMEND, 6'd0, 2'd0, 4'd15));
    // Only the notify field of the tail may change.
    send_command(make_cmd(sjd_pkg::MODE_AMEND, 6'd63, 2'd3, 4'd0));
    send_command(make_cmd(sjd_pkg::MODE_POP, 6'd0, 2'd0, 4'd0));
    send_command(make_cmd(sjd_pkg::MODE_POP, 6'd0, 2'd0, 4'd0));
    send_command(make_cmd(sjd_pkg::MODE_POP, 6'd0, 2'd0, 4'd0));
    send_command(make_cmd(sjd_pkg::MODE_POP, 6'd63, 2'd3, 4'd15));
    send_command(make_cmd(FIRST_UNUSED_MODE, 6'd63, 2'd3, 4'd15));
    send_command(make_cmd(LAST_UNUSED_MODE - 3'd1, 6'd63, 2'd3, 4'd15));
    send_command(make_cmd(LAST_UNUSED_MODE, 6'd63, 2'd3, 4'd15));
    send_command(make_cmd(sjd_pkg::MODE_INSERT, 6'd21, 2'd1, 4'd5));
    send_command(make_cmd(sjd_pkg::MODE_INSERT, 6'd63, 2'd3, 4'd15));
    send_command(make_cmd(sjd_pkg::MODE_PUSH, 6'd10, 2'd2, 4'd6));
    send_command(make_cmd(FIRST_UNUSED_MODE, 6'd0, 2'd0, 4'd0));
    send_command(make_cmd(sjd_pkg::MODE_CLEAR, 6'd63, 2'd3, 4'd15));
    send_command(make_cmd(sjd_pkg::MODE_AMEND, 6'd1, 2'd1, 4'd1));
    send_command(make_cmd(sjd_pkg::MODE_POP, 6'd0, 2'd0, 4'd0));

    // Random: each fill phase runs the queue into full, so push and insert
    // on a full queue get exercised; the drain phase walks it back to empty.
    for (round = 0; round < 3; round++) begin
      no_gaps = (round == 1);
      run_phase(FILL_PHASE, 90);
      no_gaps = 1'b0;
      run_phase(MIX_PHASE, 60);
      run_phase(DRAIN_PHASE, 80);
    end

    req_valid <= 1'b0;
    while (shadow.awaited_results.size() != 0) @(posedge clk);
    // Give a stray extra result time to show up.
    repeat (8) @(posedge clk);
    if (shadow.errors == 0) $display("tb_shifting_job_deque: PASS");
    else $display("tb_shifting_job_deque: FAIL");
    $finish;
  end
endmodule

// File: filelist.f
rtl/sjd_pkg.sv
rtl/sjd_cell.sv
rtl/shifting_job_deque.sv
test/tb_shifting_job_deque.sv
